[sv/nd_cubic_spline_eval_macros.svh]
// Assertion macros shared by the spline evaluator RTL
`ifndef ND_CUBIC_SPLINE_EVAL_MACROS_SVH
`define ND_CUBIC_SPLINE_EVAL_MACROS_SVH

// same-cycle implication, checked on clk, off during rst
`define CSPL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define CSPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/cspl_pkg.sv]
// Shared constants, types and codes for the cubic spline evaluator
`timescale 1ns / 1ps
`default_nettype none
package cspl_pkg;
  localparam int AXES       = 3;
  localparam int NODES      = 16;
  localparam int MAX_AXES   = 3;
  localparam int CSPAN      = NODES + 2;
  localparam int COEF_DEPTH = CSPAN ** AXES;
  localparam int NODE_DEPTH = NODES ** AXES;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int NEAR_W     = $clog2(NODES);
  localparam int CW         = $clog2(CSPAN + 1);
  localparam int AX_W       = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int DATA_W     = 32;
  localparam int MUL_W      = 34;
  localparam int PRODW      = 2 * MUL_W;
  localparam int W_W        = 19;
  localparam int P_W        = 24;
  localparam int ACC_W      = 64;
  localparam int OUT_W      = 48;
  localparam int Q_ONE      = 65536;

  typedef enum logic [1:0] {
    REQ_LOAD_COEF = 2'd0,
    REQ_LOAD_NODE = 2'd1,
    REQ_EVAL      = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_AXIS0   = 3'd0,
    CFG_ORIGIN_AXIS1   = 3'd1,
    CFG_ORIGIN_AXIS2   = 3'd2,
    CFG_INV_STEP_AXIS0 = 3'd3,
    CFG_INV_STEP_AXIS1 = 3'd4,
    CFG_INV_STEP_AXIS2 = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUB, ST_MUL, ST_POS, ST_F2, ST_F3, ST_G2, ST_G3,
    ST_TADDR, ST_WMUL, ST_WRND, ST_CMUL, ST_ACC, ST_ROUND, ST_NRD, ST_NOUT
  } state_t;

  typedef struct packed {
    logic               coef_we;
    logic               node_we;
    logic               coef_rd;
    logic               node_rd;
    logic [COEF_AW-1:0] coef_addr;
    logic [NODE_AW-1:0] node_addr;
    logic [DATA_W-1:0]  wdata;
  } tbl_cmd_t;
endpackage
`default_nettype wire

[sv/cspl_mul.sv]
// Shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module cspl_mul
  import cspl_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic signed [MUL_W-1:0] op_a,
  input  wire logic signed [MUL_W-1:0] op_b,
  output logic signed [PRODW-1:0]      prod
);
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end
endmodule
`default_nettype wire

[sv/cspl_tables.sv]
// Coefficient and node value memories, one port each, registered read
`timescale 1ns / 1ps
`default_nettype none
module cspl_tables
  import cspl_pkg::*;
(
  input  wire logic              clk,
  input  wire tbl_cmd_t          cmd,
  output logic [DATA_W-1:0]      coef_q,
  output logic [DATA_W-1:0]      node_q
);
  logic [DATA_W-1:0] coef_mem [COEF_DEPTH];
  logic [DATA_W-1:0] node_mem [NODE_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.coef_we) begin
      coef_mem[cmd.coef_addr] <= cmd.wdata;
    end
    if (cmd.coef_rd) begin
      coef_q <= coef_mem[cmd.coef_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.node_we) begin
      node_mem[cmd.node_addr] <= cmd.wdata;
    end
    if (cmd.node_rd) begin
      node_q <= node_mem[cmd.node_addr];
    end
  end
endmodule
`default_nettype wire

[sv/nd_cubic_spline_eval.sv]
// Top level: sequencer and datapath of the tensor-product cubic spline evaluator
// Load transaction: busy stays low, the next transaction may follow at once.
// Evaluate inside the grid: every term whose coefficient indices all stay below CSPAN
// passes AXES+1 times through the one shared multiplier; other terms are skipped.
// done strobes one cycle. The receiver cannot stall. rst (synchronous) idles the
// sequencer, sets origins to 0 and reciprocal spacings to 1.0; table contents are not
// cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "nd_cubic_spline_eval_macros.svh"
module nd_cubic_spline_eval
  import cspl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               req_type,
  input  wire logic [12:0]              table_index,
  input  wire logic signed [DATA_W-1:0] table_data,
  input  wire logic signed [DATA_W-1:0] coord_axis0,
  input  wire logic signed [DATA_W-1:0] coord_axis1,
  input  wire logic signed [DATA_W-1:0] coord_axis2,
  input  wire logic                     cfg_we,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_data,
  output logic                          done,
  output logic signed [OUT_W-1:0]       spline_value,
  output logic                          inside_grid
);
  state_t state, state_next;

  logic [DATA_W-1:0] org [MAX_AXES];
  logic [DATA_W-1:0] inv [MAX_AXES];
  logic [DATA_W-1:0] coord [MAX_AXES];

  logic signed [DATA_W:0] d;
  logic [AX_W-1:0]        ax, k;
  logic                   outside;
  logic [NEAR_W-1:0]      near [AXES];
  logic [NEAR_W-1:0]      cell_idx [AXES];
  logic [15:0]            f;
  logic [32:0]            sq;
  logic [W_W-1:0]         w [AXES][4];
  logic [1:0]             j [AXES];
  logic [P_W-1:0]         prod;
  logic signed [ACC_W-1:0] acc;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PRODW-1:0] mul_p;
  tbl_cmd_t                cmd;
  logic [DATA_W-1:0]       coef_q, node_q;

  logic [63:0]        p_val;
  logic [63:0]        near_sum;
  logic               p_above;
  logic [16:0]        g;
  logic [51:0]        cube52, sq52, w_hi_sum, w_lo_sum;
  logic [W_W-1:0]     w_hi, w_lo, w_sel;
  logic [1:0]         j_adv [AXES];
  logic               j_last, skip;
  logic [CW-1:0]      c [AXES];
  logic [COEF_AW-1:0] ci;
  logic [NODE_AW-1:0] ni;
  logic               ax_last, k_last, coef_ok, node_ok;
  logic [39:0]        wrnd_sum;
  logic signed [ACC_W:0] r_sum, r_sh;
  logic               r_ovf;
  logic signed [OUT_W-1:0] sat_val;
  state_t             nxt_in, nxt_out;

  cspl_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  cspl_tables u_tables (
    .clk    (clk),
    .cmd    (cmd),
    .coef_q (coef_q),
    .node_q (node_q)
  );

  assign busy = (state != ST_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_AXES; i++) begin
        org[i] <= '0;
        inv[i] <= DATA_W'(Q_ONE);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_AXIS0:   org[0] <= cfg_data;
        CFG_ORIGIN_AXIS1:   org[1] <= cfg_data;
        CFG_ORIGIN_AXIS2:   org[2] <= cfg_data;
        CFG_INV_STEP_AXIS0: inv[0] <= cfg_data;
        CFG_INV_STEP_AXIS1: inv[1] <= cfg_data;
        CFG_INV_STEP_AXIS2: inv[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared combinational helpers
  always_comb begin
    logic carry;
    p_val    = mul_p[63:0];
    p_above  = p_val > (64'(NODES - 1) << 32);
    near_sum = p_val + 64'h7FFF_FFFF;
    g        = 17'(Q_ONE) - {1'b0, f};
    cube52   = 52'(mul_p[48:0]);
    sq52     = 52'(sq);
    w_hi_sum = (52'd4 << 48) + 52'd3 * cube52 - ((52'd6 * sq52) << 16) + (52'd1 << 31);
    w_lo_sum = cube52 + (52'd1 << 31);
    w_hi     = w_hi_sum[W_W+31:32];
    w_lo     = W_W'(w_lo_sum[51:32]);
    w_sel    = w[k][j[k]];
    wrnd_sum = mul_p[39:0] + 40'd32768;
    ax_last  = (ax == AX_W'(AXES - 1));
    k_last   = (k == AX_W'(AXES - 1));
    coef_ok  = ({19'b0, table_index} < 32'(COEF_DEPTH));
    node_ok  = ({19'b0, table_index} < 32'(NODE_DEPTH));

    // odometer over the four nonzero terms per axis, axis 0 fastest
    carry  = 1'b1;
    j_last = 1'b1;
    skip   = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      j_last   = j_last & (j[a] == 2'd3);
      j_adv[a] = j[a] + {1'b0, carry};
      carry    = carry & (j[a] == 2'd3);
      c[a]     = CW'(cell_idx[a]) + CW'(j[a]);
      skip     = skip | (c[a] == CW'(CSPAN));
    end
    ci = '0;
    ni = '0;
    for (int a = AXES - 1; a >= 0; a--) begin
      ci = COEF_AW'(ci * COEF_AW'(CSPAN)) + COEF_AW'(c[a]);
      ni = NODE_AW'(ni * NODE_AW'(NODES)) + NODE_AW'(near[a]);
    end

    // round half up to Q16.16, saturate to the result width
    r_sum   = {acc[ACC_W-1], acc} + (ACC_W + 1)'(32768);
    r_sh    = r_sum >>> 16;
    r_ovf   = !((&r_sh[ACC_W:OUT_W-1]) || !(|r_sh[ACC_W:OUT_W-1]));
    sat_val = r_ovf ? (r_sh[ACC_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}})
                    : r_sh[OUT_W-1:0];

    nxt_in  = ax_last ? (outside ? ST_NRD : ST_TADDR) : ST_SUB;
    nxt_out = ax_last ? ST_NRD : ST_SUB;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_ROUND) || (state == ST_NOUT);
    end
  end

  // next state, multiplier operands, table port
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    cmd        = '0;
    cmd.wdata  = table_data;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (req_type)
            REQ_LOAD_COEF: begin
              cmd.coef_we   = coef_ok;
              cmd.coef_addr = COEF_AW'(table_index);
            end
            REQ_LOAD_NODE: begin
              cmd.node_we   = node_ok;
              cmd.node_addr = NODE_AW'(table_index);
            end
            REQ_EVAL: state_next = ST_SUB;
            default: ;
          endcase
        end
      end
      ST_SUB: state_next = ST_MUL;
      ST_MUL: begin
        if (d[DATA_W]) begin
          state_next = nxt_out;
        end else begin
          mul_a      = {2'b0, d[DATA_W-1:0]};
          mul_b      = {2'b0, inv[ax]};
          state_next = ST_POS;
        end
      end
      ST_POS: begin
        if (p_above) begin
          state_next = nxt_out;
        end else begin
          mul_a      = {18'b0, p_val[31:16]};
          mul_b      = {18'b0, p_val[31:16]};
          state_next = ST_F2;
        end
      end
      ST_F2: begin
        mul_a      = {18'b0, f};
        mul_b      = mul_p[MUL_W-1:0];
        state_next = ST_F3;
      end
      ST_F3: begin
        mul_a      = {17'b0, g};
        mul_b      = {17'b0, g};
        state_next = ST_G2;
      end
      ST_G2: begin
        mul_a      = {17'b0, g};
        mul_b      = mul_p[MUL_W-1:0];
        state_next = ST_G3;
      end
      ST_G3: state_next = nxt_in;
      ST_TADDR: begin
        if (skip) begin
          state_next = j_last ? ST_ROUND : ST_TADDR;
        end else begin
          cmd.coef_rd   = 1'b1;
          cmd.coef_addr = ci;
          state_next    = ST_WMUL;
        end
      end
      ST_WMUL: begin
        mul_a      = MUL_W'(prod);
        mul_b      = MUL_W'(w_sel);
        state_next = ST_WRND;
      end
      ST_WRND: state_next = k_last ? ST_CMUL : ST_WMUL;
      ST_CMUL: begin
        mul_a      = {{(MUL_W-DATA_W){coef_q[DATA_W-1]}}, coef_q};
        mul_b      = MUL_W'(prod);
        state_next = ST_ACC;
      end
      ST_ACC: state_next = j_last ? ST_ROUND : ST_TADDR;
      ST_ROUND: state_next = ST_IDLE;
      ST_NRD: begin
        cmd.node_rd   = 1'b1;
        cmd.node_addr = ni;
        state_next    = ST_NOUT;
      end
      ST_NOUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start && req_type == REQ_EVAL) begin
          coord[0] <= coord_axis0;
          coord[1] <= coord_axis1;
          coord[2] <= coord_axis2;
          ax       <= '0;
          outside  <= 1'b0;
          acc      <= '0;
          for (int a = 0; a < AXES; a++) begin
            j[a] <= '0;
          end
        end
      end
      ST_SUB: d <= {coord[ax][DATA_W-1], coord[ax]} - {org[ax][DATA_W-1], org[ax]};
      ST_MUL: begin
        if (d[DATA_W]) begin
          outside  <= 1'b1;
          near[ax] <= '0;
          if (!ax_last) ax <= ax + 1'b1;
        end
      end
      ST_POS: begin
        if (p_above) begin
          outside  <= 1'b1;
          near[ax] <= NEAR_W'(NODES - 1);
          if (!ax_last) ax <= ax + 1'b1;
        end else begin
          near[ax]     <= near_sum[32+NEAR_W-1:32];
          cell_idx[ax] <= p_val[32+NEAR_W-1:32];
          f            <= p_val[31:16];
        end
      end
      ST_F2: sq <= mul_p[32:0];
      ST_F3: begin
        w[ax][3] <= w_lo;
        w[ax][1] <= w_hi;
      end
      ST_G2: sq <= mul_p[32:0];
      ST_G3: begin
        w[ax][0] <= w_lo;
        w[ax][2] <= w_hi;
        if (!ax_last) ax <= ax + 1'b1;
      end
      ST_TADDR: begin
        if (skip) begin
          j <= j_adv;
        end else begin
          prod <= P_W'(Q_ONE);
          k    <= '0;
        end
      end
      ST_WRND: begin
        prod <= wrnd_sum[P_W+15:16];
        if (!k_last) k <= k + 1'b1;
      end
      ST_ACC: begin
        acc <= acc + mul_p[ACC_W-1:0];
        j   <= j_adv;
      end
      ST_ROUND: begin
        spline_value <= sat_val;
        inside_grid  <= 1'b1;
      end
      ST_NOUT: begin
        spline_value <= {{(OUT_W-DATA_W){node_q[DATA_W-1]}}, node_q};
        inside_grid  <= 1'b0;
      end
      default: ;
    endcase
  end

  `CSPL_ASSERT_NEXT(a_eval_starts, start && !busy && req_type == REQ_EVAL, busy, "evaluate transaction not taken")
  `CSPL_ASSERT_NEXT(a_load_quiet, start && !busy && req_type != REQ_EVAL, !busy && !done, "load transaction started work")
  `CSPL_ASSERT_IMPLY(a_done_idle, done, !busy, "result strobe while sequencer busy")
  `CSPL_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
endmodule
`default_nettype wire
